// ===== hw/rtl/escc_pkg.sv =====
// Shared types, constants and width helpers of the calibrated conversion unit.
package escc_pkg;

    localparam int FRAC_BITS_DEF = 12;

    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 16;
    localparam int TPT_W      = 10;
    localparam int HPT_W      = 8;
    localparam int DEN_W      = 16;
    localparam int PROD_W     = RAW_W + TPT_W;
    localparam int PRES_W     = 24;
    localparam int READING_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int TEMP_FRAC_DROP = 3;
    localparam int HUM_FRAC_DROP  = 1;
    localparam int HUM_FULL_PCT   = 100;

    localparam logic [HPT_W-1:0] HUM_POINT_MAX = 8'd200;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_POINT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_POINT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_RAW0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_RAW1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_POINT0  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_POINT1  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_RAW0    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_RAW1    = 3'd7;

    typedef enum logic [OP_W-1:0] {
        KIND_TEMP = 2'd0,
        KIND_HUM  = 2'd1,
        KIND_PRES = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  err;
        logic  q_neg;
    } t_ctrl;

    typedef struct packed {
        logic [TPT_W-1:0] temp_point0_x8;
        logic [TPT_W-1:0] temp_point1_x8;
        logic [RAW_W-1:0] temp_raw0;
        logic [RAW_W-1:0] temp_raw1;
        logic [HPT_W-1:0] hum_point0_x2;
        logic [HPT_W-1:0] hum_point1_x2;
        logic [RAW_W-1:0] hum_raw0;
        logic [RAW_W-1:0] hum_raw1;
    } t_cfg;

    // Magnitude of the scaled numerator; equals the quotient width.
    function automatic int mag_width(input int frac_bits);
        mag_width = PROD_W + frac_bits - TEMP_FRAC_DROP;
    endfunction

    // Signed width of the offset term, wide enough for a pressure sample too.
    function automatic int base_width(input int frac_bits);
        int w;
        begin
            w = TPT_W + frac_bits - TEMP_FRAC_DROP;
            if (w < PRES_W) begin
                w = PRES_W;
            end
            base_width = w + 1;
        end
    endfunction

endpackage

// ===== hw/rtl/escc_in_if.sv =====
// Input channel carrying the reading kind and the raw sample bytes.
interface escc_in_if;
    import escc_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] sample_xl;
    logic [BYTE_W-1:0] sample_low;
    logic [BYTE_W-1:0] sample_high;

    modport source (output valid, output op, output sample_xl, output sample_low,
                    output sample_high, input ready);
    modport sink (input valid, input op, input sample_xl, input sample_low,
                  input sample_high, output ready);
endinterface

// ===== hw/rtl/escc_out_if.sv =====
// Output channel carrying the calibrated reading and its status.
interface escc_out_if;
    import escc_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [READING_W-1:0] reading;
    logic                        status;

    modport source (output valid, output reading, output status, input ready);
    modport sink (input valid, input reading, input status, output ready);
endinterface

// ===== hw/rtl/escc_front.sv =====
// Front end: calibration differences, magnitudes and the scaled numerator product.
module escc_front #(
    parameter int FRAC_BITS = escc_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  escc_pkg::t_cfg                              i_cfg,
    escc_in_if.sink                                     i_item,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output escc_pkg::t_ctrl                             o_ctrl,
    output logic [escc_pkg::mag_width(FRAC_BITS)-1:0]   o_mag,
    output logic [escc_pkg::DEN_W-1:0]                  o_den,
    output logic [escc_pkg::base_width(FRAC_BITS)-1:0]  o_base
);
    import escc_pkg::*;

    localparam int MAG_W      = mag_width(FRAC_BITS);
    localparam int BASE_W     = base_width(FRAC_BITS);
    localparam int TEMP_SHIFT = FRAC_BITS - TEMP_FRAC_DROP;
    localparam int HUM_SHIFT  = FRAC_BITS - HUM_FRAC_DROP;

    logic [RAW_W-1:0]   raw16;
    logic [RAW_W-1:0]   r0;
    logic [RAW_W-1:0]   r1;
    logic [TPT_W-1:0]   p0;
    logic [TPT_W-1:0]   p1;
    logic [RAW_W:0]     d_raw;
    logic [RAW_W:0]     neg_raw;
    logic [TPT_W:0]     d_pt;
    logic [TPT_W:0]     neg_pt;
    logic [RAW_W:0]     d_den;
    logic [RAW_W:0]     neg_den;
    t_ctrl              n_s1_ctrl;
    logic [PROD_W-1:0]  prod;

    logic               r_s1_valid;
    t_ctrl              r_s1_ctrl;
    logic [RAW_W-1:0]   r_mag_raw;
    logic [TPT_W-1:0]   r_mag_pt;
    logic [DEN_W-1:0]   r_mag_den;
    logic [TPT_W-1:0]   r_p0;
    logic [PRES_W-1:0]  r_pres;

    logic               r_s2_valid;
    t_ctrl              r_s2_ctrl;
    logic [MAG_W-1:0]   r_mag;
    logic [DEN_W-1:0]   r_den;
    logic [BASE_W-1:0]  r_base;
    logic [MAG_W-1:0]   n_mag;
    logic [BASE_W-1:0]  n_base;

    logic               s1_ready;
    logic               s2_ready;

    assign s2_ready     = !r_s2_valid || i_ready;
    assign s1_ready     = !r_s1_valid || s2_ready;
    assign i_item.ready = s1_ready;

    always_comb begin
        raw16          = {i_item.sample_high, i_item.sample_low};
        r0             = '0;
        r1             = '0;
        p0             = '0;
        p1             = '0;
        n_s1_ctrl.kind = t_kind'(i_item.op);
        n_s1_ctrl.err  = 1'b0;
        unique case (n_s1_ctrl.kind)
            KIND_TEMP: begin
                r0            = i_cfg.temp_raw0;
                r1            = i_cfg.temp_raw1;
                p0            = i_cfg.temp_point0_x8;
                p1            = i_cfg.temp_point1_x8;
                n_s1_ctrl.err = (r0 == r1);
            end
            KIND_HUM: begin
                r0            = i_cfg.hum_raw0;
                r1            = i_cfg.hum_raw1;
                p0            = TPT_W'(i_cfg.hum_point0_x2);
                p1            = TPT_W'(i_cfg.hum_point1_x2);
                n_s1_ctrl.err = (r0 == r1) || (i_cfg.hum_point0_x2 > HUM_POINT_MAX)
                                || (i_cfg.hum_point1_x2 > HUM_POINT_MAX);
            end
            KIND_PRES: begin
                n_s1_ctrl.err = 1'b0;
            end
            KIND_NONE: begin
                n_s1_ctrl.err = 1'b1;
            end
        endcase
        d_raw           = {raw16[RAW_W-1], raw16} - {r0[RAW_W-1], r0};
        neg_raw         = -d_raw;
        d_pt            = {1'b0, p1} - {1'b0, p0};
        neg_pt          = -d_pt;
        d_den           = {r1[RAW_W-1], r1} - {r0[RAW_W-1], r0};
        neg_den         = -d_den;
        n_s1_ctrl.q_neg = d_raw[RAW_W] ^ d_pt[TPT_W] ^ d_den[RAW_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_item.valid) begin
            r_s1_ctrl <= n_s1_ctrl;
            r_mag_raw <= d_raw[RAW_W] ? neg_raw[RAW_W-1:0] : d_raw[RAW_W-1:0];
            r_mag_pt  <= d_pt[TPT_W] ? neg_pt[TPT_W-1:0] : d_pt[TPT_W-1:0];
            r_mag_den <= d_den[RAW_W] ? neg_den[DEN_W-1:0] : d_den[DEN_W-1:0];
            r_p0      <= p0;
            r_pres    <= {i_item.sample_high, i_item.sample_low, i_item.sample_xl};
        end
    end

    assign prod = PROD_W'(r_mag_raw) * PROD_W'(r_mag_pt);

    always_comb begin
        n_mag  = '0;
        n_base = '0;
        unique case (r_s1_ctrl.kind)
            KIND_TEMP: begin
                n_mag  = MAG_W'(prod) << TEMP_SHIFT;
                n_base = BASE_W'(r_p0) << TEMP_SHIFT;
            end
            KIND_HUM: begin
                n_mag  = MAG_W'(prod) << HUM_SHIFT;
                n_base = BASE_W'(r_p0) << HUM_SHIFT;
            end
            KIND_PRES: begin
                n_base = {{(BASE_W-PRES_W){r_pres[PRES_W-1]}}, r_pres};
            end
            KIND_NONE: begin
                n_base = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_ctrl <= r_s1_ctrl;
            r_mag     <= n_mag;
            r_den     <= r_mag_den;
            r_base    <= n_base;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_ctrl  = r_s2_ctrl;
    assign o_mag   = r_mag;
    assign o_den   = r_den;
    assign o_base  = r_base;

endmodule

// ===== hw/rtl/escc_div_cell.sv =====
// One restoring divider cell: produces one quotient bit and passes the item on.
module escc_div_cell #(
    parameter int FRAC_BITS = escc_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  escc_pkg::t_ctrl                             i_ctrl,
    input  logic [escc_pkg::DEN_W-1:0]                  i_rem,
    input  logic [escc_pkg::mag_width(FRAC_BITS)-1:0]   i_dq,
    input  logic [escc_pkg::DEN_W-1:0]                  i_den,
    input  logic [escc_pkg::base_width(FRAC_BITS)-1:0]  i_base,
    output logic                                        o_valid,
    input  logic                                        i_ready,
    output escc_pkg::t_ctrl                             o_ctrl,
    output logic [escc_pkg::DEN_W-1:0]                  o_rem,
    output logic [escc_pkg::mag_width(FRAC_BITS)-1:0]   o_dq,
    output logic [escc_pkg::DEN_W-1:0]                  o_den,
    output logic [escc_pkg::base_width(FRAC_BITS)-1:0]  o_base
);
    import escc_pkg::*;

    localparam int MAG_W  = mag_width(FRAC_BITS);
    localparam int BASE_W = base_width(FRAC_BITS);

    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic               q_bit;

    logic               r_valid;
    t_ctrl              r_ctrl;
    logic [DEN_W-1:0]   r_rem;
    logic [MAG_W-1:0]   r_dq;
    logic [DEN_W-1:0]   r_den;
    logic [BASE_W-1:0]  r_base;

    assign trial   = {i_rem, i_dq[MAG_W-1]};
    assign diff    = trial - {1'b0, i_den};
    assign q_bit   = (trial >= {1'b0, i_den});
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctrl <= i_ctrl;
            r_rem  <= q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_dq   <= {i_dq[MAG_W-2:0], q_bit};
            r_den  <= i_den;
            r_base <= i_base;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;
    assign o_rem   = r_rem;
    assign o_dq    = r_dq;
    assign o_den   = r_den;
    assign o_base  = r_base;

endmodule

// ===== hw/rtl/escc_finish.sv =====
// Back end: signed quotient plus offset, then saturation or clamping into the output register.
module escc_finish #(
    parameter int FRAC_BITS = escc_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  escc_pkg::t_ctrl                             i_ctrl,
    input  logic [escc_pkg::mag_width(FRAC_BITS)-1:0]   i_dq,
    input  logic [escc_pkg::base_width(FRAC_BITS)-1:0]  i_base,
    escc_out_if.source                                  o_result
);
    import escc_pkg::*;

    localparam int MAG_W  = mag_width(FRAC_BITS);
    localparam int BASE_W = base_width(FRAC_BITS);
    localparam int SUM_W  = MAG_W + 2;

    localparam logic [SUM_W-1:0] HUM_TOP = SUM_W'(HUM_FULL_PCT) << FRAC_BITS;

    logic [SUM_W-1:0]      q_ext;
    logic [SUM_W-1:0]      q_sgn;
    logic [SUM_W-1:0]      base_ext;

    logic                  r_s1_valid;
    t_ctrl                 r_s1_ctrl;
    logic [SUM_W-1:0]      r_sum;

    logic                  fits;
    logic [READING_W-1:0]  n_reading;

    logic                  r_valid;
    logic [READING_W-1:0]  r_reading;
    logic                  r_status;

    logic                  s1_ready;
    logic                  s2_ready;

    assign s2_ready = !r_valid || o_result.ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    // A pressure sample passes through, so the divider output is not used.
    assign q_ext    = {2'b00, i_dq};
    assign q_sgn    = (i_ctrl.kind == KIND_PRES) ? '0 :
                      i_ctrl.q_neg ? (~q_ext + SUM_W'(1)) : q_ext;
    assign base_ext = {{(SUM_W-BASE_W){i_base[BASE_W-1]}}, i_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_ctrl <= i_ctrl;
            r_sum     <= base_ext + q_sgn;
        end
    end

    assign fits = (&r_sum[SUM_W-1:READING_W-1]) || !(|r_sum[SUM_W-1:READING_W-1]);

    always_comb begin
        if (r_s1_ctrl.err) begin
            n_reading = '0;
        end else if (r_s1_ctrl.kind == KIND_HUM) begin
            if (r_sum[SUM_W-1]) begin
                n_reading = '0;
            end else if (r_sum > HUM_TOP) begin
                n_reading = HUM_TOP[READING_W-1:0];
            end else begin
                n_reading = r_sum[READING_W-1:0];
            end
        end else if (fits) begin
            n_reading = r_sum[READING_W-1:0];
        end else if (r_sum[SUM_W-1]) begin
            n_reading = {1'b1, {(READING_W-1){1'b0}}};
        end else begin
            n_reading = {1'b0, {(READING_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s2_ready) begin
            r_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_reading <= n_reading;
            r_status  <= r_s1_ctrl.err;
        end
    end

    assign o_result.valid   = r_valid;
    assign o_result.reading = r_reading;
    assign o_result.status  = r_status;

endmodule

// ===== hw/rtl/env_sensor_calibrated_conversion_unit.sv =====
// Top level of the calibrated conversion unit: configuration registers and the divider chain.
//
// Each transfer on i_item carries a reading kind (temperature, humidity,
// pressure) and up to three raw bytes, and gives exactly one transfer on
// o_result with a status bit and a reading, scaled by 2^FRAC_BITS except for pressure.
// Calibration points are written through i_cfg_we, i_cfg_index and i_cfg_data by the user
// only while the unit is idle, not enforced by the unit; each write is registered in r_cfg.
// The datapath is a pipeline: two front stages form the calibration
// differences and the scaled product, FRAC_BITS + 23 divider cells each
// resolve one quotient bit, and two back stages add the offset and
// saturate or clamp. One item is accepted per cycle unless a stall at
// o_result has backed up to the first front stage.
// Every stage holds its item while the next one is full, so a stall at
// o_result fills the pipeline from the end; earlier stages keep accepting
// until their own register is occupied, and gaps between items close up.
// Reset clears all calibration registers to zero and empties the pipeline.
module env_sensor_calibrated_conversion_unit #(
    parameter int FRAC_BITS = escc_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [escc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [escc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    escc_in_if.sink                        i_item,
    escc_out_if.source                     o_result
);
    import escc_pkg::*;

    localparam int MAG_W  = mag_width(FRAC_BITS);
    localparam int BASE_W = base_width(FRAC_BITS);

    t_cfg               r_cfg;
    t_cfg               n_cfg;

    logic [MAG_W:0]     w_valid;
    logic [MAG_W:0]     w_ready;
    t_ctrl              w_ctrl [0:MAG_W];
    logic [DEN_W-1:0]   w_rem  [0:MAG_W];
    logic [MAG_W-1:0]   w_dq   [0:MAG_W];
    logic [DEN_W-1:0]   w_den  [0:MAG_W];
    logic [BASE_W-1:0]  w_base [0:MAG_W];

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP_POINT0: n_cfg.temp_point0_x8 = i_cfg_data[TPT_W-1:0];
                CFG_TEMP_POINT1: n_cfg.temp_point1_x8 = i_cfg_data[TPT_W-1:0];
                CFG_TEMP_RAW0:   n_cfg.temp_raw0      = i_cfg_data[RAW_W-1:0];
                CFG_TEMP_RAW1:   n_cfg.temp_raw1      = i_cfg_data[RAW_W-1:0];
                CFG_HUM_POINT0:  n_cfg.hum_point0_x2  = i_cfg_data[HPT_W-1:0];
                CFG_HUM_POINT1:  n_cfg.hum_point1_x2  = i_cfg_data[HPT_W-1:0];
                CFG_HUM_RAW0:    n_cfg.hum_raw0       = i_cfg_data[RAW_W-1:0];
                CFG_HUM_RAW1:    n_cfg.hum_raw1       = i_cfg_data[RAW_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    escc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (i_item),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_ctrl  (w_ctrl[0]),
        .o_mag   (w_dq[0]),
        .o_den   (w_den[0]),
        .o_base  (w_base[0])
    );

    assign w_rem[0] = '0;

    for (genvar k = 0; k < MAG_W; k++) begin : g_cell
        escc_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_ctrl  (w_ctrl[k]),
            .i_rem   (w_rem[k]),
            .i_dq    (w_dq[k]),
            .i_den   (w_den[k]),
            .i_base  (w_base[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_ctrl  (w_ctrl[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_dq    (w_dq[k+1]),
            .o_den   (w_den[k+1]),
            .o_base  (w_base[k+1])
        );
    end

    escc_finish #(
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[MAG_W]),
        .o_ready  (w_ready[MAG_W]),
        .i_ctrl   (w_ctrl[MAG_W]),
        .i_dq     (w_dq[MAG_W]),
        .i_base   (w_base[MAG_W]),
        .o_result (o_result)
    );

endmodule

// ===== dv/tb_env_sensor_calibrated_conversion_unit.sv =====
// Self-checking testbench for the calibrated conversion unit with randomized handshakes.
`timescale 1ns / 1ps

module tb_env_sensor_calibrated_conversion_unit;
    import escc_pkg::*;

    localparam int FRAC_BITS      = FRAC_BITS_DEF;
    localparam int LATENCY        = FRAC_BITS + 27;
    localparam int NUM_REGS       = 8;
    localparam int RAND_PHASES    = 14;
    localparam int RAND_PER_PHASE = 125;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam longint READING_MAX = 64'sd2147483647;
    localparam longint READING_MIN = -64'sd2147483648;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] xl;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
    } t_sample;

    typedef struct {
        logic signed [READING_W-1:0] reading;
        logic                        status;
    } t_reading;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    escc_in_if  in_ch ();
    escc_out_if out_ch ();

    env_sensor_calibrated_conversion_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_item(in_ch),
        .o_result(out_ch)
    );

    t_cfg     cal;
    t_sample  pending_samples[$];
    t_reading expected_readings[$];
    t_reading want;
    logic     drain_hold = 1'b0;
    int       n_sent;
    int       n_checked;
    int       n_invalid;
    int       n_fail;
    int       n_settings;
    int       idle_cycles;
    int       burst_left;
    int       gap_left;
    int       sink_mode;
    int       mode_left;
    int       run_left;
    logic     run_high = 1'b0;
    logic     rdy;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_reading calibrate(input t_sample s);
        t_reading res;
        longint   raw;
        longint   r0;
        longint   r1;
        longint   p0;
        longint   p1;
        longint   scale;
        longint   val;
        res.reading = '0;
        res.status  = 1'b0;
        raw = longint'($signed({s.hi, s.lo}));
        case (s.kind)
            KIND_TEMP: begin
                r0 = longint'($signed(cal.temp_raw0));
                r1 = longint'($signed(cal.temp_raw1));
                if (r0 == r1) begin
                    res.status = 1'b1;
                end else begin
                    p0 = longint'(cal.temp_point0_x8);
                    p1 = longint'(cal.temp_point1_x8);
                    scale = longint'(1) << (FRAC_BITS - TEMP_FRAC_DROP);
                    val = p0 * scale + ((raw - r0) * (p1 - p0) * scale) / (r1 - r0);
                    if (val > READING_MAX) begin
                        val = READING_MAX;
                    end else if (val < READING_MIN) begin
                        val = READING_MIN;
                    end
                    res.reading = val[READING_W-1:0];
                end
            end
            KIND_HUM: begin
                r0 = longint'($signed(cal.hum_raw0));
                r1 = longint'($signed(cal.hum_raw1));
                p0 = longint'(cal.hum_point0_x2);
                p1 = longint'(cal.hum_point1_x2);
                if (r0 == r1 || p0 > longint'(HUM_POINT_MAX) || p1 > longint'(HUM_POINT_MAX)) begin
                    res.status = 1'b1;
                end else begin
                    scale = longint'(1) << (FRAC_BITS - HUM_FRAC_DROP);
                    val = p0 * scale + ((raw - r0) * (p1 - p0) * scale) / (r1 - r0);
                    if (val < 0) begin
                        val = 0;
                    end else if (val > (longint'(HUM_FULL_PCT) << FRAC_BITS)) begin
                        val = longint'(HUM_FULL_PCT) << FRAC_BITS;
                    end
                    res.reading = val[READING_W-1:0];
                end
            end
            KIND_PRES: begin
                res.reading = {{(READING_W - PRES_W){s.hi[BYTE_W-1]}}, s.hi, s.lo, s.xl};
            end
            default: begin
                res.status = 1'b1;
            end
        endcase
        return res;
    endfunction

    function automatic logic [RAW_W-1:0] rand_cal_raw(input logic [RAW_W-1:0] other);
        logic [RAW_W-1:0] r;
        case ($urandom_range(0, 5))
            0: r = other + RAW_W'($urandom_range(0, 6)) - RAW_W'(3);
            1: r = 16'h8000;
            2: r = 16'h7FFF;
            default: r = RAW_W'($urandom);
        endcase
        return r;
    endfunction

    function automatic logic [HPT_W-1:0] rand_hum_point();
        logic [HPT_W-1:0] p;
        case ($urandom_range(0, 9))
            0: p = HPT_W'($urandom_range(201, 255));
            1: p = '0;
            2: p = HUM_POINT_MAX;
            default: p = HPT_W'($urandom_range(0, 200));
        endcase
        return p;
    endfunction

    function automatic logic [TPT_W-1:0] rand_temp_point();
        logic [TPT_W-1:0] p;
        case ($urandom_range(0, 5))
            0: p = '0;
            1: p = '1;
            default: p = TPT_W'($urandom);
        endcase
        return p;
    endfunction

    function automatic t_cfg rand_cal();
        t_cfg c;
        c.temp_point0_x8 = rand_temp_point();
        c.temp_point1_x8 = rand_temp_point();
        c.temp_raw0      = rand_cal_raw(RAW_W'($urandom));
        c.temp_raw1      = rand_cal_raw(c.temp_raw0);
        c.hum_point0_x2  = rand_hum_point();
        c.hum_point1_x2  = rand_hum_point();
        c.hum_raw0       = rand_cal_raw(RAW_W'($urandom));
        c.hum_raw1       = rand_cal_raw(c.hum_raw0);
        return c;
    endfunction

    function automatic t_sample rand_sample();
        t_sample          s;
        logic [RAW_W-1:0] base;
        int               pick;
        pick = $urandom_range(0, 9);
        s.kind = (pick < 3) ? KIND_TEMP : (pick < 6) ? KIND_HUM : (pick < 9) ? KIND_PRES : KIND_NONE;
        {s.hi, s.lo, s.xl} = 24'($urandom);
        if (s.kind == KIND_TEMP || s.kind == KIND_HUM) begin
            pick = $urandom_range(0, 9);
            if (s.kind == KIND_TEMP) begin
                base = $urandom_range(0, 1) ? cal.temp_raw0 : cal.temp_raw1;
            end else begin
                base = $urandom_range(0, 1) ? cal.hum_raw0 : cal.hum_raw1;
            end
            if (pick < 3) begin
                {s.hi, s.lo} = base + RAW_W'($urandom_range(0, 64)) - RAW_W'(32);
            end else if (pick == 3) begin
                {s.hi, s.lo} = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
        end
        return s;
    endfunction

    task automatic push(input t_kind kind, input logic [7:0] xl, input logic [7:0] lo,
                        input logic [7:0] hi);
        t_sample s;
        s.kind = kind;
        s.xl   = xl;
        s.lo   = lo;
        s.hi   = hi;
        pending_samples.push_back(s);
    endtask

    task automatic settle();
        while (pending_samples.size() != 0 || in_ch.valid || expected_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic load_cfg(input t_cfg c);
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] word;
        for (int i = 0; i < NUM_REGS; i++) begin
            reg_idx = CFG_IDX_W'(i);
            case (reg_idx)
                CFG_TEMP_POINT0: word = {6'($urandom), c.temp_point0_x8};
                CFG_TEMP_POINT1: word = {6'($urandom), c.temp_point1_x8};
                CFG_TEMP_RAW0:   word = c.temp_raw0;
                CFG_TEMP_RAW1:   word = c.temp_raw1;
                CFG_HUM_POINT0:  word = {8'($urandom), c.hum_point0_x2};
                CFG_HUM_POINT1:  word = {8'($urandom), c.hum_point1_x2};
                CFG_HUM_RAW0:    word = c.hum_raw0;
                default:         word = c.hum_raw1;
            endcase
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_idx;
            i_cfg_data  <= word;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cal = c;
        n_settings++;
        @(negedge i_clk);
    endtask

    // Sender: presents queued samples in bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_readings.push_back(calibrate(pending_samples.pop_front()));
                n_sent++;
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (drain_hold || pending_samples.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    in_ch.valid       <= 1'b1;
                    in_ch.op          <= pending_samples[0].kind;
                    in_ch.sample_xl   <= pending_samples[0].xl;
                    in_ch.sample_low  <= pending_samples[0].lo;
                    in_ch.sample_high <= pending_samples[0].hi;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        if ($urandom_range(0, 3) == 0) begin
                            gap_left = 0;
                        end else begin
                            gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 5);
                        end
                    end
                end
            end
        end
    end

    // Receiver: checks each result transfer and stalls on its own pattern.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result, reading %0d status %0b", $time,
                         out_ch.reading, out_ch.status);
                n_fail++;
            end else begin
                want = expected_readings.pop_front();
                n_checked++;
                if (want.status) begin
                    n_invalid++;
                end
                if (out_ch.reading !== want.reading) begin
                    $display("%0t: reading mismatch, expected %0d actual %0d", $time,
                             want.reading, out_ch.reading);
                    n_fail++;
                end
                if (out_ch.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0b actual %0b", $time,
                             want.status, out_ch.status);
                    n_fail++;
                end
            end
        end
        if (mode_left == 0) begin
            sink_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(64, 400);
        end
        mode_left--;
        case (sink_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom_range(0, 1));
            2: rdy = ($urandom_range(0, 7) != 0);
            default: begin
                if (run_left == 0) begin
                    run_high = !run_high;
                    run_left = $urandom_range(1, 25);
                end
                run_left--;
                rdy = run_high;
            end
        endcase
        out_ch.ready <= rdy;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_cfg c;
        in_ch.valid       = 1'b0;
        in_ch.op          = '0;
        in_ch.sample_xl   = '0;
        in_ch.sample_low  = '0;
        in_ch.sample_high = '0;
        out_ch.ready      = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        cal               = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // All calibration registers at zero: both spans are empty.
        push(KIND_TEMP, 8'hA5, 8'h34, 8'h12);
        push(KIND_HUM, 8'h00, 8'hFF, 8'h7F);
        push(KIND_PRES, 8'h00, 8'h00, 8'h00);
        push(KIND_PRES, 8'hFF, 8'hFF, 8'h7F);
        push(KIND_PRES, 8'h00, 8'h00, 8'h80);
        push(KIND_PRES, 8'hFF, 8'hFF, 8'hFF);
        push(KIND_NONE, 8'h5A, 8'hC3, 8'h3C);
        settle();

        c = '0;
        c.temp_point1_x8 = '1;
        c.temp_raw0      = 16'h8000;
        c.temp_raw1      = 16'h7FFF;
        c.hum_point1_x2  = HUM_POINT_MAX;
        c.hum_raw0       = 16'h8000;
        c.hum_raw1       = 16'h7FFF;
        load_cfg(c);
        push(KIND_TEMP, 8'h00, 8'h00, 8'h80);
        push(KIND_TEMP, 8'hFF, 8'hFF, 8'h7F);
        push(KIND_TEMP, 8'hFF, 8'h00, 8'h00);
        push(KIND_TEMP, 8'h00, 8'h00, 8'h00);
        push(KIND_HUM, 8'h00, 8'h00, 8'h80);
        push(KIND_HUM, 8'hFF, 8'hFF, 8'h7F);
        settle();

        // Unit spans drive temperature into saturation and humidity into both clamps.
        c = '0;
        c.temp_point0_x8 = '1;
        c.temp_raw1      = 16'h0001;
        c.hum_point0_x2  = HUM_POINT_MAX;
        c.hum_raw0       = 16'h0001;
        load_cfg(c);
        push(KIND_TEMP, 8'h00, 8'hFF, 8'h7F);
        push(KIND_TEMP, 8'h00, 8'h00, 8'h80);
        push(KIND_HUM, 8'h00, 8'hFF, 8'h7F);
        push(KIND_HUM, 8'h00, 8'h00, 8'h80);
        settle();

        c = '0;
        c.temp_point0_x8 = 10'd200;
        c.temp_point1_x8 = 10'd400;
        c.temp_raw0      = 16'h1234;
        c.temp_raw1      = 16'h1234;
        c.hum_point0_x2  = 8'd255;
        c.hum_point1_x2  = 8'd201;
        c.hum_raw1       = 16'd100;
        load_cfg(c);
        push(KIND_TEMP, 8'h00, 8'h34, 8'h12);
        push(KIND_HUM, 8'h00, 8'h32, 8'h00);
        push(KIND_NONE, 8'hFF, 8'hFF, 8'hFF);
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            load_cfg(rand_cal());
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                pending_samples.push_back(rand_sample());
            end
            if (ph % 4 == 1) begin
                while (pending_samples.size() > RAND_PER_PHASE / 2) begin
                    @(negedge i_clk);
                end
                drain_hold = 1'b1;
                while (in_ch.valid || expected_readings.size() != 0) begin
                    @(negedge i_clk);
                end
                drain_hold = 1'b0;
            end
            settle();
        end

        repeat (LATENCY + 8) @(posedge i_clk);
        if (expected_readings.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_readings.size());
            n_fail += expected_readings.size();
        end
        $display("Converted %0d samples under %0d calibration settings.", n_sent, n_settings);
        $display("Checked %0d results, %0d of them flagged invalid.", n_checked, n_invalid);
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== env_sensor_calibrated_conversion_unit.f =====
hw/rtl/escc_pkg.sv
hw/rtl/escc_in_if.sv
hw/rtl/escc_out_if.sv
hw/rtl/escc_front.sv
hw/rtl/escc_div_cell.sv
hw/rtl/escc_finish.sv
hw/rtl/env_sensor_calibrated_conversion_unit.sv
dv/tb_env_sensor_calibrated_conversion_unit.sv
